### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/mlc3b_pkg.sv
// ---------------------------------------------------------------------------
// mlc3b_pkg
// types, control word bit positions and constants of the lc-3b unit
// ---------------------------------------------------------------------------
package mlc3b_pkg;

  localparam int MemWordsDef    = 32768;
  localparam int CtrlRowsDef    = 64;
  localparam int MemLatencyDef  = 5;
  localparam int NumRegsDef     = 8;
  localparam int CwW            = 50;
  localparam int WaddrW         = 15;
  localparam int CfgIdxW        = 2;

  localparam logic [5:0]  RESET_STATE   = 6'd18;
  localparam logic [5:0]  EXC_STATE     = 6'd10;
  localparam logic [15:0] PROTECT_LIMIT = 16'h3000;
  localparam logic [15:0] START_PC_RST  = 16'h3000;
  localparam logic [15:0] SSP_RST       = 16'h3000;

  localparam logic [7:0] EXC_NONE  = 8'd0;
  localparam logic [7:0] EXC_PROT  = 8'd2;
  localparam logic [7:0] EXC_ALIGN = 8'd3;
  localparam logic [7:0] EXC_OPC   = 8'd4;

  localparam logic [2:0] COND_MEM  = 3'd1;
  localparam logic [2:0] COND_BEN  = 3'd2;
  localparam logic [2:0] COND_IR11 = 3'd3;
  localparam logic [2:0] COND_INT  = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_START_PC = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SSP      = 2'd1;

  // control word bit numbers, counted from the ird end
  localparam int B_IRD = 0,  B_COND1 = 1,  B_COND0 = 2,  B_J5 = 3;
  localparam int B_LDMAR = 9, B_LDMDR = 10, B_LDIR = 11, B_LDBEN = 12;
  localparam int B_LDREG = 13, B_LDCC = 14, B_LDPC = 15, B_GPC = 16;
  localparam int B_GMDR = 17, B_GALU = 18, B_GMARMUX = 19, B_GSHF = 20;
  localparam int B_PCMUX1 = 21, B_PCMUX0 = 22, B_DRMUX = 23, B_SR1MUX = 24;
  localparam int B_ADDR1MUX = 25, B_ADDR2MUX1 = 26, B_ADDR2MUX0 = 27;
  localparam int B_MARMUX = 28, B_ALUK1 = 29, B_ALUK0 = 30, B_MIOEN = 31;
  localparam int B_RW = 32, B_DSIZE = 33, B_LSHF1 = 34, B_LDSSP = 35;
  localparam int B_LDUSP = 36, B_LDVEC = 37, B_LDPRIV = 38, B_GSP = 39;
  localparam int B_GVEC = 40, B_GPSR = 41, B_GPC2 = 42, B_COND2 = 43;
  localparam int B_DRMUX1 = 44, B_SR1MUX1 = 45, B_SPMUX1 = 46, B_SPMUX0 = 47;
  localparam int B_VECMUX = 48, B_PSRMUX = 49;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_WROW = 2'd1,
    OP_WMEM = 2'd2,
    OP_RMEM = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]     operation;
    logic [14:0]    address;
    logic [CwW-1:0] load_data;
    logic           interrupt_request;
  } in_t;

  typedef struct packed {
    logic [5:0]  micro_state;
    logic [15:0] program_count;
    logic [15:0] bus_value;
    logic [15:0] instruction_word;
    logic [2:0]  condition_codes;
    logic        privilege;
    logic        halted;
    logic [15:0] read_word;
  } out_t;

  typedef struct packed {
    logic [5:0]  state;
    logic [15:0] pc;
    logic [15:0] bus;
    logic [15:0] ir;
    logic [2:0]  nzp;
    logic        priv;
    logic [15:0] mar;
  } arch_t;

  typedef struct packed {
    logic              lo;
    logic              hi;
    logic [WaddrW-1:0] addr;
    logic [15:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        data;
  } cfg_wr_t;

  function automatic logic cbit(input logic [CwW-1:0] w, input int j);
    return w[CwW-1-j];
  endfunction

endpackage

### sv/mlc3b_cstore.sv
// ---------------------------------------------------------------------------
// mlc3b_cstore
// control store memory, read each cycle at the next microstate with bypass
// ---------------------------------------------------------------------------
module mlc3b_cstore #(
  parameter int CONTROL_ROWS = mlc3b_pkg::CtrlRowsDef
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(CONTROL_ROWS)-1:0] wr_addr_i,
  input  logic [mlc3b_pkg::CwW-1:0]       wr_data_i,
  input  logic [$clog2(CONTROL_ROWS)-1:0] rd_addr_i,
  output logic [mlc3b_pkg::CwW-1:0]       row_o
);

  logic [mlc3b_pkg::CwW-1:0] mem_q [CONTROL_ROWS];
  logic [mlc3b_pkg::CwW-1:0] row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      row_q <= wr_data_i;
    end else begin
      row_q <= mem_q[rd_addr_i];
    end
  end

  assign row_o = row_q;

endmodule

### sv/mlc3b_mstore.sv
// ---------------------------------------------------------------------------
// mlc3b_mstore
// main store in two byte lanes; port a follows mar, port b serves reads
// ---------------------------------------------------------------------------
module mlc3b_mstore #(
  parameter int MEM_WORDS = mlc3b_pkg::MemWordsDef
) (
  input  logic                              clk_i,
  input  mlc3b_pkg::mem_wr_t                wr_i,
  input  logic [mlc3b_pkg::WaddrW-1:0]      a_addr_i,
  output logic [15:0]                       a_data_o,
  input  logic                              b_en_i,
  input  logic [mlc3b_pkg::WaddrW-1:0]      b_addr_i,
  output logic [15:0]                       b_data_o
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [7:0]    lo_q [MEM_WORDS];
  logic [7:0]    hi_q [MEM_WORDS];
  logic [AW-1:0] wa, ra, rb;
  logic [7:0]    a_lo_q, a_hi_q;
  logic [15:0]   b_q;

  assign wa = wr_i.addr[AW-1:0];
  assign ra = a_addr_i[AW-1:0];
  assign rb = b_addr_i[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.lo) begin
      lo_q[wa] <= wr_i.data[7:0];
    end
    if (wr_i.hi) begin
      hi_q[wa] <= wr_i.data[15:8];
    end
    if (wr_i.lo && (wa == ra)) begin
      a_lo_q <= wr_i.data[7:0];
    end else begin
      a_lo_q <= lo_q[ra];
    end
    if (wr_i.hi && (wa == ra)) begin
      a_hi_q <= wr_i.data[15:8];
    end else begin
      a_hi_q <= hi_q[ra];
    end
    if (b_en_i) begin
      b_q <= {hi_q[rb], lo_q[rb]};
    end
  end

  assign a_data_o = {a_hi_q, a_lo_q};
  assign b_data_o = b_q;

endmodule

### sv/mlc3b_core.sv
// ---------------------------------------------------------------------------
// mlc3b_core
// datapath, memory timing, exception checks and microsequencer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlc3b_core #(
  parameter int MEM_LATENCY = mlc3b_pkg::MemLatencyDef,
  parameter int NUM_REGS    = mlc3b_pkg::NumRegsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic                        irq_i,
  input  mlc3b_pkg::cfg_wr_t          cfg_i,
  input  logic [mlc3b_pkg::CwW-1:0]   row_i,
  input  logic [15:0]                 mem_data_i,
  output mlc3b_pkg::mem_wr_t          mem_wr_o,
  output mlc3b_pkg::arch_t            arch_o
);

  logic [15:0] gpr_q [NUM_REGS];
  logic [15:0] pc_q, ir_q, mar_q, mdr_q, usp_q, ssp_q, bus_q, latch_q;
  logic [7:0]  vec_q, exc_q;
  logic [2:0]  nzp_q, cnt_q;
  logic        priv_q, ben_q, rdy_q, pend_q;
  logic [5:0]  state_q;

  logic        run;
  logic [2:0]  cnt_n;
  logic        rdy_n;
  logic [15:0] latch_n;
  logic [2:0]  sr1, dr;
  logic [15:0] src1, src2, alu, shf, a1, a2, adder, marmux, sp, mdrv, bus;
  logic [15:0] vals [9];
  logic [8:0]  gates;
  logic [7:0]  exc;
  logic [5:0]  nxt, jf;
  logic [2:0]  cond;
  logic        pend_n;

  assign run = tick_i && (pc_q != 16'd0);

  // memory timing
  always_comb begin
    cnt_n = mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_MIOEN) ?
            ((cnt_q != 3'd7) ? cnt_q + 3'd1 : 3'd7) : 3'd0;
    rdy_n = rdy_q;
    if (cnt_n == 3'(MEM_LATENCY - 1)) begin
      rdy_n = 1'b1;
    end
    if (rdy_q) begin
      cnt_n = 3'd0;
      rdy_n = 1'b0;
    end
    latch_n = latch_q;
    if (rdy_q && !mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_RW)) begin
      latch_n = mem_data_i;
    end
  end

  always_comb begin
    mem_wr_o.addr = mar_q[15:1];
    mem_wr_o.data = mdr_q;
    mem_wr_o.lo   = run && rdy_q && mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_RW) &&
                    (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_DSIZE) || !mar_q[0]);
    mem_wr_o.hi   = run && rdy_q && mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_RW) &&
                    (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_DSIZE) || mar_q[0]);
  end

  // bus sources
  always_comb begin
    sr1 = mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_SR1MUX) ? ir_q[8:6] : ir_q[11:9];
    if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_SR1MUX1)) begin
      sr1 = 3'd6;
    end
    src1 = gpr_q[sr1];
    src2 = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : gpr_q[ir_q[2:0]];
    case ({mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_ALUK1),
           mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_ALUK0)})
      2'd0:    alu = src1 + src2;
      2'd1:    alu = src1 & src2;
      2'd2:    alu = src1 ^ src2;
      default: alu = src1;
    endcase
    if (ir_q[4]) begin
      shf = ir_q[5] ? 16'($signed(src1) >>> ir_q[3:0]) : (src1 >> ir_q[3:0]);
    end else begin
      shf = src1 << ir_q[3:0];
    end
    a1 = mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_ADDR1MUX) ? src1 : pc_q;
    case ({mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_ADDR2MUX1),
           mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_ADDR2MUX0)})
      2'd1:    a2 = {{10{ir_q[5]}}, ir_q[5:0]};
      2'd2:    a2 = {{7{ir_q[8]}}, ir_q[8:0]};
      2'd3:    a2 = {{5{ir_q[10]}}, ir_q[10:0]};
      default: a2 = 16'd0;
    endcase
    if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LSHF1)) begin
      a2 = {a2[14:0], 1'b0};
    end
    adder  = a1 + a2;
    marmux = mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_MARMUX) ? adder
                                                         : {7'd0, ir_q[7:0], 1'b0};
    case ({mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_SPMUX1),
           mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_SPMUX0)})
      2'd0:    sp = usp_q;
      2'd1:    sp = ssp_q;
      2'd2:    sp = src1 + 16'd2;
      default: sp = src1 - 16'd2;
    endcase
    if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_DSIZE)) begin
      mdrv = mdr_q;
    end else if (mar_q[0]) begin
      mdrv = {{8{mdr_q[15]}}, mdr_q[15:8]};
    end else begin
      mdrv = {{8{mdr_q[7]}}, mdr_q[7:0]};
    end
  end

  // single bus, several drivers keep the old value
  always_comb begin
    vals[0] = pc_q;
    vals[1] = marmux;
    vals[2] = shf;
    vals[3] = mdrv;
    vals[4] = alu;
    vals[5] = sp;
    vals[6] = {7'd1, vec_q, 1'b0};
    vals[7] = {priv_q, 12'd0, nzp_q};
    vals[8] = pc_q - 16'd2;
    gates = {mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GPC2),
             mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GPSR),
             mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GVEC),
             mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GSP),
             mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GALU),
             mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GMDR),
             mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GSHF),
             mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GMARMUX),
             mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_GPC)};
    bus = 16'd0;
    for (int k = 0; k < 9; k++) begin
      if (gates[k]) begin
        bus = bus | vals[k];
      end
    end
    if (!$onehot0(gates)) begin
      bus = bus_q;
    end
  end

  // exception checks and next microstate
  always_comb begin
    exc = mlc3b_pkg::EXC_NONE;
    if ((ir_q[15:12] != 4'hF) && priv_q && mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDMAR) &&
        (bus < mlc3b_pkg::PROTECT_LIMIT)) begin
      exc = mlc3b_pkg::EXC_PROT;
    end else if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_DSIZE) &&
                 mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDMAR) && bus[0] && priv_q) begin
      exc = mlc3b_pkg::EXC_ALIGN;
    end else if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_IRD) && (ir_q[15:13] == 3'b101)) begin
      exc = mlc3b_pkg::EXC_OPC;
    end
    jf   = row_i[mlc3b_pkg::CwW-1-mlc3b_pkg::B_J5 -: 6];
    cond = {mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_COND2),
            mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_COND1),
            mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_COND0)};
    pend_n = pend_q | irq_i;
    if (exc != mlc3b_pkg::EXC_NONE) begin
      nxt = mlc3b_pkg::EXC_STATE;
    end else if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_IRD)) begin
      nxt = {2'b00, ir_q[15:12]};
    end else begin
      case (cond)
        mlc3b_pkg::COND_MEM:  nxt = jf | {4'd0, rdy_q, 1'b0};
        mlc3b_pkg::COND_BEN:  nxt = jf | {3'd0, ben_q, 2'd0};
        mlc3b_pkg::COND_IR11: nxt = jf | {5'd0, ir_q[11]};
        mlc3b_pkg::COND_INT: begin
          nxt    = jf | {2'd0, pend_n, 3'd0};
          pend_n = 1'b0;
        end
        default:              nxt = jf;
      endcase
    end
    dr = mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_DRMUX) ? 3'd7 : ir_q[11:9];
    if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_DRMUX1)) begin
      dr = 3'd6;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        gpr_q[i] <= 16'd0;
      end
      pc_q    <= mlc3b_pkg::START_PC_RST;
      ssp_q   <= mlc3b_pkg::SSP_RST;
      ir_q    <= 16'd0;
      mar_q   <= 16'd0;
      mdr_q   <= 16'd0;
      usp_q   <= 16'd0;
      bus_q   <= 16'd0;
      latch_q <= 16'd0;
      vec_q   <= 8'd0;
      exc_q   <= 8'd0;
      nzp_q   <= 3'b010;
      cnt_q   <= 3'd0;
      priv_q  <= 1'b1;
      ben_q   <= 1'b0;
      rdy_q   <= 1'b0;
      pend_q  <= 1'b0;
      state_q <= mlc3b_pkg::RESET_STATE;
    end else if (cfg_i.en) begin
      if (cfg_i.idx == mlc3b_pkg::CFG_START_PC) begin
        pc_q <= cfg_i.data;
      end else if (cfg_i.idx == mlc3b_pkg::CFG_SSP) begin
        ssp_q <= cfg_i.data;
      end
    end else if (run) begin
      cnt_q   <= cnt_n;
      rdy_q   <= rdy_n;
      latch_q <= latch_n;
      pend_q  <= pend_n;
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDBEN)) begin
        ben_q <= (nzp_q[2] & ir_q[11]) | (nzp_q[1] & ir_q[10]) | (nzp_q[0] & ir_q[9]);
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDMDR)) begin
        if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_MIOEN)) begin
          mdr_q <= latch_n;
        end else if (mar_q[0]) begin
          mdr_q <= {bus[7:0], bus[7:0]};
        end else begin
          mdr_q <= bus;
        end
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDMAR)) begin
        mar_q <= bus;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDCC)) begin
        if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_PSRMUX)) begin
          nzp_q <= bus[2:0];
        end else if (bus == 16'd0) begin
          nzp_q <= 3'b010;
        end else begin
          nzp_q <= bus[15] ? 3'b100 : 3'b001;
        end
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDPC)) begin
        case ({mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_PCMUX1),
               mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_PCMUX0)})
          2'd0:    pc_q <= pc_q + 16'd2;
          2'd1:    pc_q <= bus;
          2'd2:    pc_q <= adder;
          default: pc_q <= pc_q;
        endcase
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDREG)) begin
        gpr_q[dr] <= bus;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDPRIV)) begin
        priv_q <= mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_PSRMUX) ? bus[15] : 1'b0;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDVEC)) begin
        vec_q <= mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_VECMUX) ? exc_q : 8'd1;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDUSP)) begin
        usp_q <= src1;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDSSP)) begin
        ssp_q <= src1;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDIR)) begin
        ir_q <= bus;
      end
      if (exc != mlc3b_pkg::EXC_NONE) begin
        exc_q <= exc;
      end
      bus_q   <= bus;
      state_q <= nxt;
    end
  end

  // architectural view after this cycle, for the next row and word fetch
  always_comb begin
    arch_o.state = run ? nxt : state_q;
    arch_o.pc    = pc_q;
    arch_o.bus   = run ? bus : bus_q;
    arch_o.ir    = ir_q;
    arch_o.nzp   = nzp_q;
    arch_o.priv  = priv_q;
    arch_o.mar   = mar_q;
    if (cfg_i.en && (cfg_i.idx == mlc3b_pkg::CFG_START_PC)) begin
      arch_o.pc = cfg_i.data;
    end
    if (run) begin
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDMAR)) begin
        arch_o.mar = bus;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDIR)) begin
        arch_o.ir = bus;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDPRIV)) begin
        arch_o.priv = mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_PSRMUX) ? bus[15] : 1'b0;
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDCC)) begin
        if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_PSRMUX)) begin
          arch_o.nzp = bus[2:0];
        end else if (bus == 16'd0) begin
          arch_o.nzp = 3'b010;
        end else begin
          arch_o.nzp = bus[15] ? 3'b100 : 3'b001;
        end
      end
      if (mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_LDPC)) begin
        case ({mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_PCMUX1),
               mlc3b_pkg::cbit(row_i, mlc3b_pkg::B_PCMUX0)})
          2'd0:    arch_o.pc = pc_q + 16'd2;
          2'd1:    arch_o.pc = bus;
          2'd2:    arch_o.pc = adder;
          default: arch_o.pc = pc_q;
        endcase
      end
    end
  end

  `ASSERT_NEXT(a_state_hold, !run, $stable(state_q))
  `ASSERT_NEXT(a_exc_state, run && (exc != mlc3b_pkg::EXC_NONE),
               state_q == mlc3b_pkg::EXC_STATE)
  `ASSERT_NEXT(a_ready_pulse, run && rdy_q, !rdy_q && (cnt_q == 3'd0))

endmodule

### sv/microcoded_lc3b_processor_unit.sv
// A microcoded LC-3b machine: every input transaction gives one result transaction, and one
// transaction is taken per clock while the output register is free, so ticks run back to back.
// The tick executes in the cycle it is accepted, from a control row that the control store
// memory fetched in the previous cycle at the then-next microstate; main store port a keeps the
// word at MAR ready the same way, and port b serves read-word transactions. Results sit in one
// output register, so a new transaction is taken whenever that register is empty or being
// drained. After reset nothing is taken until prime_q is set, while the first control row
// and memory word are fetched. A configuration write is taken in any cycle and holds off input
// transactions in that cycle; write configuration only while no transaction is in flight.
module microcoded_lc3b_processor_unit #(
  parameter int MEM_WORDS    = mlc3b_pkg::MemWordsDef,
  parameter int CONTROL_ROWS = mlc3b_pkg::CtrlRowsDef,
  parameter int MEM_LATENCY  = mlc3b_pkg::MemLatencyDef,
  parameter int NUM_REGS     = mlc3b_pkg::NumRegsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mlc3b_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mlc3b_pkg::out_t                   out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mlc3b_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);

  localparam int RowAW = $clog2(CONTROL_ROWS);

  logic                      prime_q, out_valid_q, rd_sel_q;
  logic                      acc, tick;
  mlc3b_pkg::op_e            op;
  mlc3b_pkg::arch_t          arch, arch_q;
  mlc3b_pkg::cfg_wr_t        cfg;
  mlc3b_pkg::mem_wr_t        core_wr, mem_wr;
  logic [mlc3b_pkg::CwW-1:0] row;
  logic [15:0]               a_data, b_data;

  assign op          = mlc3b_pkg::op_e'(in_data_i.operation);
  assign in_ready_o  = prime_q && !cfg_valid_i && (!out_valid_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign tick        = acc && (op == mlc3b_pkg::OP_TICK);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg.en   = cfg_valid_i;
    cfg.idx  = cfg_index_i;
    cfg.data = cfg_data_i;
  end

  always_comb begin
    mem_wr = core_wr;
    if (acc && (op == mlc3b_pkg::OP_WMEM)) begin
      mem_wr.lo   = 1'b1;
      mem_wr.hi   = 1'b1;
      mem_wr.addr = in_data_i.address;
      mem_wr.data = in_data_i.load_data[15:0];
    end
  end

  mlc3b_core #(
    .MEM_LATENCY (MEM_LATENCY),
    .NUM_REGS    (NUM_REGS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .irq_i      (in_data_i.interrupt_request),
    .cfg_i      (cfg),
    .row_i      (row),
    .mem_data_i (a_data),
    .mem_wr_o   (core_wr),
    .arch_o     (arch)
  );

  mlc3b_cstore #(
    .CONTROL_ROWS (CONTROL_ROWS)
  ) u_cstore (
    .clk_i     (clk_i),
    .wr_en_i   (acc && (op == mlc3b_pkg::OP_WROW)),
    .wr_addr_i (in_data_i.address[RowAW-1:0]),
    .wr_data_i (in_data_i.load_data),
    .rd_addr_i (arch.state[RowAW-1:0]),
    .row_o     (row)
  );

  mlc3b_mstore #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mstore (
    .clk_i    (clk_i),
    .wr_i     (mem_wr),
    .a_addr_i (arch.mar[15:1]),
    .a_data_o (a_data),
    .b_en_i   (acc && (op == mlc3b_pkg::OP_RMEM)),
    .b_addr_i (in_data_i.address),
    .b_data_o (b_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prime_q <= 1'b1;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      arch_q   <= arch;
      rd_sel_q <= (op == mlc3b_pkg::OP_RMEM);
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    out_data_o.micro_state      = arch_q.state;
    out_data_o.program_count    = arch_q.pc;
    out_data_o.bus_value        = arch_q.bus;
    out_data_o.instruction_word = arch_q.ir;
    out_data_o.condition_codes  = arch_q.nzp;
    out_data_o.privilege        = arch_q.priv;
    out_data_o.halted           = (arch_q.pc == 16'd0);
    out_data_o.read_word        = rd_sel_q ? b_data : 16'd0;
  end

endmodule

### verif/microcoded_lc3b_processor_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// microcoded lc-3b processor unit testbench
// A short table of stimulus is run first: control row and memory word loads,
// read-backs, and single ticks through hand-built microcode rows. After it,
// random traffic runs in several idling phases with different start pc and
// system stack settings. Every result is checked field by field against a
// typed view or a cycle-level model of the datapath and the microsequencer.
// ---------------------------------------------------------------------------
module microcoded_lc3b_processor_unit_tb;

  typedef struct {
    mlc3b_pkg::op_e  op;
    logic [14:0]     addr;
    logic [49:0]     data;
    logic            irq;
    logic            at_state;
    logic            typed;
    mlc3b_pkg::out_t view;
  } stim_row_t;

  localparam int GATE_BITS [9] = '{mlc3b_pkg::B_GPC, mlc3b_pkg::B_GMARMUX,
                                    mlc3b_pkg::B_GSHF, mlc3b_pkg::B_GMDR,
                                    mlc3b_pkg::B_GALU, mlc3b_pkg::B_GSP,
                                    mlc3b_pkg::B_GVEC, mlc3b_pkg::B_GPSR,
                                    mlc3b_pkg::B_GPC2};
  localparam mlc3b_pkg::out_t RESET_VIEW = '{micro_state: mlc3b_pkg::RESET_STATE,
                                             program_count: mlc3b_pkg::START_PC_RST,
                                             bus_value: 16'h0, instruction_word: 16'h0,
                                             condition_codes: 3'b010, privilege: 1'b1,
                                             halted: 1'b0, read_word: 16'h0};

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  mlc3b_pkg::in_t  in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  mlc3b_pkg::out_t out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [mlc3b_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0]     cfg_data_i = '0;

  int   fails = 0;
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  mlc3b_pkg::out_t expected_views[$];
  stim_row_t stim_table[$];

  // machine state copy
  logic [49:0] m_rows [64];
  logic [15:0] m_mem [32768];
  bit          m_wr [32768];
  logic [15:0] m_gpr [8];
  logic [15:0] m_pc = mlc3b_pkg::START_PC_RST, m_ir = '0, m_mar = '0, m_mdr = '0;
  logic [15:0] m_usp = '0, m_ssp = mlc3b_pkg::SSP_RST, m_bus = '0, m_latch = '0;
  logic [2:0]  m_nzp = 3'b010, m_cnt = '0;
  logic        m_priv = 1'b1, m_ben = 1'b0, m_ready = 1'b0, m_irq = 1'b0;
  logic [5:0]  m_state = mlc3b_pkg::RESET_STATE;
  logic [7:0]  m_vec = '0, m_exc = mlc3b_pkg::EXC_NONE;

  microcoded_lc3b_processor_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic ctl(input logic [49:0] w, input int j);
    return w[49-j];
  endfunction

  function automatic logic [49:0] cw_bit(input int j);
    return 50'(1) << (49 - j);
  endfunction

  function automatic logic [49:0] cw_next(input logic [5:0] v);
    logic [49:0] w;
    w = '0;
    for (int k = 0; k < 6; k++) w[49-(mlc3b_pkg::B_J5+k)] = v[5-k];
    return w;
  endfunction

  function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
    logic [15:0] r;
    r = v;
    for (int k = bits; k < 16; k++) r[k] = v[bits-1];
    return r;
  endfunction

  task automatic machine_tick();
    logic [49:0] uw;
    logic [15:0] ir, src1, src2, alu, shf, a1, a2, adder, marmux, sp, bus, old;
    logic [15:0] vals [9];
    logic [2:0]  cnt, sr1, dr, cond;
    logic [5:0]  nxt, jf;
    logic [7:0]  exc;
    logic [3:0]  opc;
    logic        ready_now, next_ready;
    int          nsel;
    uw = m_rows[m_state];
    ir = m_ir;
    ready_now = m_ready;
    next_ready = ready_now;
    cnt = ctl(uw, mlc3b_pkg::B_MIOEN) ? ((m_cnt < 3'd7) ? m_cnt + 3'd1 : 3'd7) : 3'd0;
    if (cnt == 3'(mlc3b_pkg::MemLatencyDef - 1)) next_ready = 1'b1;
    if (ready_now) begin
      if (ctl(uw, mlc3b_pkg::B_RW)) begin
        old = m_mem[m_mar[15:1]];
        if (ctl(uw, mlc3b_pkg::B_DSIZE)) old = m_mdr;
        else if (m_mar[0]) old = {m_mdr[15:8], old[7:0]};
        else old = {old[15:8], m_mdr[7:0]};
        m_mem[m_mar[15:1]] = old;
      end else begin
        m_latch = m_mem[m_mar[15:1]];
      end
      cnt = 3'd0;
      next_ready = 1'b0;
    end
    m_cnt = cnt;

    sr1 = ctl(uw, mlc3b_pkg::B_SR1MUX) ? ir[8:6] : ir[11:9];
    if (ctl(uw, mlc3b_pkg::B_SR1MUX1)) sr1 = 3'd6;
    src1 = m_gpr[sr1];
    src2 = ir[5] ? sext(ir, 5) : m_gpr[ir[2:0]];
    case ({ctl(uw, mlc3b_pkg::B_ALUK1), ctl(uw, mlc3b_pkg::B_ALUK0)})
      2'd0: alu = src1 + src2;
      2'd1: alu = src1 & src2;
      2'd2: alu = src1 ^ src2;
      default: alu = src1;
    endcase
    if (ir[4]) shf = ir[5] ? 16'($signed(src1) >>> ir[3:0]) : src1 >> ir[3:0];
    else shf = src1 << ir[3:0];
    a1 = ctl(uw, mlc3b_pkg::B_ADDR1MUX) ? src1 : m_pc;
    case ({ctl(uw, mlc3b_pkg::B_ADDR2MUX1), ctl(uw, mlc3b_pkg::B_ADDR2MUX0)})
      2'd1: a2 = sext(ir, 6);
      2'd2: a2 = sext(ir, 9);
      2'd3: a2 = sext(ir, 11);
      default: a2 = '0;
    endcase
    if (ctl(uw, mlc3b_pkg::B_LSHF1)) a2 = a2 << 1;
    adder = a1 + a2;
    marmux = ctl(uw, mlc3b_pkg::B_MARMUX) ? adder : {7'b0, ir[7:0], 1'b0};
    case ({ctl(uw, mlc3b_pkg::B_SPMUX1), ctl(uw, mlc3b_pkg::B_SPMUX0)})
      2'd0: sp = m_usp;
      2'd1: sp = m_ssp;
      2'd2: sp = src1 + 16'd2;
      default: sp = src1 - 16'd2;
    endcase

    vals[0] = m_pc;
    vals[1] = marmux;
    vals[2] = shf;
    vals[3] = ctl(uw, mlc3b_pkg::B_DSIZE) ? m_mdr : sext(m_mar[0] ? m_mdr >> 8 : m_mdr, 8);
    vals[4] = alu;
    vals[5] = sp;
    vals[6] = 16'h0200 | {7'b0, m_vec, 1'b0};
    vals[7] = {m_priv, 12'b0, m_nzp};
    vals[8] = m_pc - 16'd2;
    nsel = 0;
    bus = '0;
    for (int k = 0; k < 9; k++) begin
      if (ctl(uw, GATE_BITS[k])) begin
        nsel++;
        bus = vals[k];
      end
    end
    if (nsel > 1) bus = m_bus;

    opc = ir[15:12];
    exc = mlc3b_pkg::EXC_NONE;
    if (opc != 4'hF && m_priv && ctl(uw, mlc3b_pkg::B_LDMAR) &&
        bus < mlc3b_pkg::PROTECT_LIMIT)
      exc = mlc3b_pkg::EXC_PROT;
    else if (ctl(uw, mlc3b_pkg::B_DSIZE) && ctl(uw, mlc3b_pkg::B_LDMAR) && bus[0] && m_priv)
      exc = mlc3b_pkg::EXC_ALIGN;
    else if (ctl(uw, mlc3b_pkg::B_IRD) && ir[15:13] == 3'b101)
      exc = mlc3b_pkg::EXC_OPC;

    if (exc != mlc3b_pkg::EXC_NONE) begin
      nxt = mlc3b_pkg::EXC_STATE;
    end else if (ctl(uw, mlc3b_pkg::B_IRD)) begin
      nxt = {2'b0, opc};
    end else begin
      jf = '0;
      for (int k = 0; k < 6; k++) jf = {jf[4:0], ctl(uw, mlc3b_pkg::B_J5 + k)};
      cond = {ctl(uw, mlc3b_pkg::B_COND2), ctl(uw, mlc3b_pkg::B_COND1),
              ctl(uw, mlc3b_pkg::B_COND0)};
      case (cond)
        mlc3b_pkg::COND_MEM:  nxt = jf | {4'b0, ready_now, 1'b0};
        mlc3b_pkg::COND_BEN:  nxt = jf | {3'b0, m_ben, 2'b0};
        mlc3b_pkg::COND_IR11: nxt = jf | {5'b0, ir[11]};
        mlc3b_pkg::COND_INT: begin
          nxt = jf | {2'b0, m_irq, 3'b0};
          m_irq = 1'b0;
        end
        default: nxt = jf;
      endcase
    end

    if (ctl(uw, mlc3b_pkg::B_LDBEN))
      m_ben = (m_nzp[2] & ir[11]) | (m_nzp[1] & ir[10]) | (m_nzp[0] & ir[9]);
    if (ctl(uw, mlc3b_pkg::B_LDMDR)) begin
      if (ctl(uw, mlc3b_pkg::B_MIOEN)) m_mdr = m_latch;
      else if (m_mar[0]) m_mdr = {bus[7:0], bus[7:0]};
      else m_mdr = bus;
    end
    if (ctl(uw, mlc3b_pkg::B_LDMAR)) m_mar = bus;
    if (ctl(uw, mlc3b_pkg::B_LDCC)) begin
      if (ctl(uw, mlc3b_pkg::B_PSRMUX)) m_nzp = bus[2:0];
      else m_nzp = (bus == 16'h0) ? 3'b010 : (bus[15] ? 3'b100 : 3'b001);
    end
    if (ctl(uw, mlc3b_pkg::B_LDPC)) begin
      case ({ctl(uw, mlc3b_pkg::B_PCMUX1), ctl(uw, mlc3b_pkg::B_PCMUX0)})
        2'd0: m_pc = m_pc + 16'd2;
        2'd1: m_pc = bus;
        2'd2: m_pc = adder;
        default: m_pc = m_pc;
      endcase
    end
    if (ctl(uw, mlc3b_pkg::B_LDREG)) begin
      dr = ctl(uw, mlc3b_pkg::B_DRMUX) ? 3'd7 : ir[11:9];
      if (ctl(uw, mlc3b_pkg::B_DRMUX1)) dr = 3'd6;
      m_gpr[dr] = bus;
    end
    if (ctl(uw, mlc3b_pkg::B_LDPRIV)) m_priv = ctl(uw, mlc3b_pkg::B_PSRMUX) ? bus[15] : 1'b0;
    if (ctl(uw, mlc3b_pkg::B_LDVEC)) m_vec = ctl(uw, mlc3b_pkg::B_VECMUX) ? m_exc : 8'd1;
    if (ctl(uw, mlc3b_pkg::B_LDUSP)) m_usp = src1;
    if (ctl(uw, mlc3b_pkg::B_LDSSP)) m_ssp = src1;
    if (ctl(uw, mlc3b_pkg::B_LDIR)) m_ir = bus;
    if (exc != mlc3b_pkg::EXC_NONE) m_exc = exc;
    m_ready = next_ready;
    m_bus = bus;
    m_state = nxt;
  endtask

  task automatic machine_step(input mlc3b_pkg::in_t it, output mlc3b_pkg::out_t view);
    logic [15:0] rd;
    rd = '0;
    case (mlc3b_pkg::op_e'(it.operation))
      mlc3b_pkg::OP_TICK: begin
        if (m_pc != 16'h0) begin
          if (it.interrupt_request) m_irq = 1'b1;
          machine_tick();
        end
      end
      mlc3b_pkg::OP_WROW: m_rows[it.address[5:0]] = it.load_data;
      mlc3b_pkg::OP_WMEM: begin
        m_mem[it.address] = it.load_data[15:0];
        m_wr[it.address] = 1'b1;
      end
      default: rd = m_mem[it.address];
    endcase
    view = '{micro_state: m_state, program_count: m_pc, bus_value: m_bus,
             instruction_word: m_ir, condition_codes: m_nzp, privilege: m_priv,
             halted: (m_pc == 16'h0), read_word: rd};
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    fails++;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    mlc3b_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected transaction", out_data_o.program_count, 16'h0);
      end else begin
        want = expected_views.pop_front();
        if (out_data_o.micro_state != want.micro_state)
          report_mismatch("micro_state", 16'(out_data_o.micro_state),
                          16'(want.micro_state));
        if (out_data_o.program_count != want.program_count)
          report_mismatch("program_count", out_data_o.program_count, want.program_count);
        if (out_data_o.bus_value != want.bus_value)
          report_mismatch("bus_value", out_data_o.bus_value, want.bus_value);
        if (out_data_o.instruction_word != want.instruction_word)
          report_mismatch("instruction_word", out_data_o.instruction_word,
                          want.instruction_word);
        if (out_data_o.condition_codes != want.condition_codes)
          report_mismatch("condition_codes", 16'(out_data_o.condition_codes),
                          16'(want.condition_codes));
        if (out_data_o.privilege != want.privilege)
          report_mismatch("privilege", 16'(out_data_o.privilege), 16'(want.privilege));
        if (out_data_o.halted != want.halted)
          report_mismatch("halted", 16'(out_data_o.halted), 16'(want.halted));
        if (out_data_o.read_word != want.read_word)
          report_mismatch("read_word", out_data_o.read_word, want.read_word);
      end
    end
  end

  // one transaction; typed views replace the model's view
  task automatic send_item(input mlc3b_pkg::in_t it, input logic typed,
                           input mlc3b_pkg::out_t typed_view);
    mlc3b_pkg::out_t view;
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    machine_step(it, view);
    expected_views.push_back(typed ? typed_view : view);
  endtask

  // an unwritten word is loaded before a read-word transaction or a memory access of a tick reaches it
  task automatic send_loaded(input mlc3b_pkg::in_t it);
    mlc3b_pkg::in_t  pre;
    mlc3b_pkg::out_t view;
    logic [14:0]     a;
    logic            need;
    need = 1'b0;
    a = '0;
    if (mlc3b_pkg::op_e'(it.operation) == mlc3b_pkg::OP_RMEM) begin
      a = it.address;
      need = !m_wr[a];
    end else if (mlc3b_pkg::op_e'(it.operation) == mlc3b_pkg::OP_TICK &&
                 m_pc != 16'h0 && m_ready) begin
      a = m_mar[15:1];
      need = !m_wr[a];
    end
    view = RESET_VIEW;
    if (need) begin
      pre = '{operation: mlc3b_pkg::OP_WMEM, address: a,
              load_data: {34'($urandom), 16'($urandom)}, interrupt_request: 1'b0};
      send_item(pre, 1'b0, view);
    end
    send_item(it, 1'b0, view);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [mlc3b_pkg::CfgIdxW-1:0] idx,
                              input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == mlc3b_pkg::CFG_START_PC) m_pc = value;
    else if (idx == mlc3b_pkg::CFG_SSP) m_ssp = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [49:0] random_row();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      for (int k = 0; k < 9; k++) r[49-GATE_BITS[k]] = 1'b0;
      if ($urandom_range(9) != 0) r[49-GATE_BITS[$urandom_range(8)]] = 1'b1;
    end
    return r[49:0];
  endfunction

  function automatic mlc3b_pkg::in_t random_item();
    mlc3b_pkg::in_t it;
    logic [63:0] r;
    int pick;
    r = {$urandom, $urandom};
    pick = $urandom_range(99);
    it.operation = (pick < 70) ? mlc3b_pkg::OP_TICK : (pick < 80) ? mlc3b_pkg::OP_WROW
                   : (pick < 88) ? mlc3b_pkg::OP_WMEM : mlc3b_pkg::OP_RMEM;
    it.address = 15'($urandom);
    it.load_data = (it.operation == mlc3b_pkg::OP_WROW) ? random_row() : r[49:0];
    it.interrupt_request = ($urandom_range(7) == 0);
    return it;
  endfunction

  task automatic add_row(input mlc3b_pkg::op_e op, input logic [14:0] addr,
                         input logic [49:0] data, input logic irq, input logic at_state,
                         input logic typed, input mlc3b_pkg::out_t view);
    stim_row_t row;
    row = '{op: op, addr: addr, data: data, irq: irq, at_state: at_state, typed: typed,
            view: view};
    stim_table.push_back(row);
  endtask

  task automatic microcode_pair(input logic [49:0] data, input logic irq);
    add_row(mlc3b_pkg::OP_WROW, '0, data, 1'b0, 1'b1, 1'b0, RESET_VIEW);
    add_row(mlc3b_pkg::OP_TICK, '0, '0, irq, 1'b0, 1'b0, RESET_VIEW);
  endtask

  initial begin
    #(64'd40_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    mlc3b_pkg::in_t  it;
    mlc3b_pkg::out_t view;
    logic [15:0]     cfg_pc [4];
    logic [15:0]     cfg_sp [4];
    int              idle_snd [4];
    int              idle_rcv [4];
    for (int k = 0; k < 8; k++) m_gpr[k] = '0;
    cfg_pc = '{16'h3000, 16'hFFFF, 16'h0000, 16'($urandom)};
    cfg_sp = '{16'hA5A5, 16'h0000, 16'hFFFF, 16'($urandom)};
    idle_snd = '{0, 77, 0, 22};
    idle_rcv = '{0, 0, 77, 22};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    view = RESET_VIEW;
    add_row(mlc3b_pkg::OP_WROW, 15'd18, '0, 1'b0, 1'b0, 1'b1, view);
    add_row(mlc3b_pkg::OP_WMEM, 15'd0, 50'hFFFF, 1'b0, 1'b0, 1'b1, view);
    view.read_word = 16'hFFFF;
    add_row(mlc3b_pkg::OP_RMEM, 15'd0, '0, 1'b0, 1'b0, 1'b1, view);
    view.read_word = 16'h0;
    add_row(mlc3b_pkg::OP_WMEM, 15'h7FFF, 50'h3_FFFF_FFFF_1234, 1'b0, 1'b0, 1'b1, view);
    view.read_word = 16'h1234;
    add_row(mlc3b_pkg::OP_RMEM, 15'h7FFF, '0, 1'b0, 1'b0, 1'b1, view);
    foreach (stim_table[i]) begin
      it = '{operation: stim_table[i].op, address: stim_table[i].addr,
             load_data: stim_table[i].data, interrupt_request: stim_table[i].irq};
      send_item(it, stim_table[i].typed, stim_table[i].view);
    end
    stim_table.delete();

    // every control row gets written before any tick
    for (int a = 0; a < 64; a++) begin
      it = '{operation: mlc3b_pkg::OP_WROW, address: 15'(a), load_data: random_row(),
             interrupt_request: 1'b0};
      send_item(it, 1'b0, view);
    end

    microcode_pair(cw_bit(mlc3b_pkg::B_GPC) | cw_bit(mlc3b_pkg::B_LDMAR) |
                   cw_bit(mlc3b_pkg::B_LDPC) | cw_next(6'd18), 1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_GMDR) | cw_bit(mlc3b_pkg::B_GALU) |
                   cw_bit(mlc3b_pkg::B_LDREG) | cw_next(6'd18), 1'b1);
    microcode_pair(cw_bit(mlc3b_pkg::B_COND2) | cw_next(6'd0), 1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_COND2) | cw_bit(mlc3b_pkg::B_COND0) | cw_next(6'd5),
                   1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_LDPC) | cw_bit(mlc3b_pkg::B_PCMUX1) |
                   cw_bit(mlc3b_pkg::B_PCMUX0) | cw_bit(mlc3b_pkg::B_GPC), 1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_GMARMUX) | cw_bit(mlc3b_pkg::B_LDMAR), 1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_LDVEC) | cw_bit(mlc3b_pkg::B_VECMUX) | cw_next(6'd20),
                   1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_GVEC) | cw_bit(mlc3b_pkg::B_LDPC) |
                   cw_bit(mlc3b_pkg::B_PCMUX0), 1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_GSP) | cw_bit(mlc3b_pkg::B_SPMUX0) |
                   cw_bit(mlc3b_pkg::B_LDIR), 1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_IRD), 1'b0);
    microcode_pair(cw_bit(mlc3b_pkg::B_LDPC) | cw_bit(mlc3b_pkg::B_PCMUX0), 1'b1);
    add_row(mlc3b_pkg::OP_TICK, '0, '0, 1'b1, 1'b0, 1'b0, RESET_VIEW);
    foreach (stim_table[i]) begin
      it = '{operation: stim_table[i].op,
             address: stim_table[i].at_state ? 15'(m_state) : stim_table[i].addr,
             load_data: stim_table[i].data, interrupt_request: stim_table[i].irq};
      send_loaded(it);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      snd_idle_pct  = idle_snd[ph];
      rcv_stall_pct = idle_rcv[ph];
      write_config(mlc3b_pkg::CFG_START_PC, cfg_pc[ph]);
      write_config(mlc3b_pkg::CFG_SSP, cfg_sp[ph]);
      for (int n = 0; n < 230; n++) begin
        if (m_pc == 16'h0 && $urandom_range(3) == 0) begin
          drain();
          write_config(mlc3b_pkg::CFG_START_PC, 16'($urandom_range(16'hFFFF, 1)));
        end
        send_loaded(random_item());
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
